// File: sv/pdr_pkg.sv
// Shared types and constants for the PPPoE discovery responder.
`timescale 1ns / 1ps
`default_nettype none
package pdr_pkg;

  typedef struct packed {
    logic        operation;
    logic [7:0]  data_byte;
    logic        frame_end;
    logic [15:0] nonce;
  } in_item_t;

  typedef struct packed {
    logic        kind;
    logic [2:0]  status;
    logic [7:0]  reply_byte;
    logic        reply_last;
    logic [11:0] reply_length;
  } out_item_t;

  typedef enum logic [1:0] {
    CMD_STAT  = 2'd0,
    CMD_BUILD = 2'd1,
    CMD_PULL  = 2'd2
  } cmd_op_t;

  typedef struct packed {
    cmd_op_t     op;
    logic [2:0]  status;
    logic        pado;
    logic [15:0] nonce;
    logic [47:0] src_mac;
    logic [15:0] plen;
  } cmd_t;

  localparam logic       OP_PUSH = 1'b0;
  localparam logic       OP_PULL = 1'b1;
  localparam logic       KIND_STATUS = 1'b0;
  localparam logic       KIND_BYTE   = 1'b1;

  localparam logic [2:0] ST_READY    = 3'd0;
  localparam logic [2:0] ST_NOT_DISC = 3'd1;
  localparam logic [2:0] ST_BAD_VER  = 3'd2;
  localparam logic [2:0] ST_BAD_CODE = 3'd3;
  localparam logic [2:0] ST_NONE     = 3'd4;

  localparam logic [2:0] REG_NAME_LEN = 3'd0;
  localparam logic [2:0] REG_WORD_0   = 3'd1;
  localparam logic [2:0] REG_WORD_1   = 3'd2;
  localparam logic [2:0] REG_WORD_2   = 3'd3;
  localparam logic [2:0] REG_WORD_3   = 3'd4;

  localparam logic [15:0] ETH_DISC   = 16'h8863;
  localparam logic [7:0]  VER_TYPE   = 8'h11;
  localparam logic [7:0]  CODE_PADI  = 8'h09;
  localparam logic [7:0]  CODE_PADR  = 8'h19;
  localparam logic [7:0]  CODE_PADO  = 8'h07;
  localparam logic [7:0]  CODE_PADS  = 8'h65;
  localparam logic [15:0] TAG_SVC    = 16'h0101;
  localparam logic [15:0] TAG_HOST   = 16'h0103;
  localparam logic [15:0] TAG_RELAY  = 16'h0110;
  localparam logic [7:0]  COOKIE_MOD = 8'd123;

endpackage
`default_nettype wire

// File: sv/pppoe_discovery_responder.sv
// Top level of the PPPoE discovery responder (PADI to PADO, PADR to PADS).
//
//  channel | ports                        | transfer when
//  --------+------------------------------+-----------------------
//  input   | in_valid in_ready in_item    | in_valid && in_ready
//  result  | out_valid out_ready out_item | out_valid && out_ready
//  config  | cfg_wr_en cfg_index cfg_data | cfg_wr_en
//
// Frame bytes and pulls are taken one per cycle while in_ready is high. A reject
// result passes the queue, result and output registers, a pull result also a
// registered tx store read. A reply build writes each header, name and cookie
// byte, reads and checks each tag header, echoes the header and value bytes of
// each echoed tag (registered rx store reads), writes the length field and holds
// off new input until done. A stalled result fills the two-entry queue, then
// drops in_ready. No clearing pass after reset. Reset is synchronous, active low.
`timescale 1ns / 1ps
`default_nettype none
module pppoe_discovery_responder #(
  parameter int FRAME_BYTES = 2048,
  parameter int NAME_BYTES  = 32
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire pdr_pkg::in_item_t  in_item,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output pdr_pkg::out_item_t      out_item,
  input  wire logic               cfg_wr_en,
  input  wire logic [2:0]         cfg_index,
  input  wire logic [63:0]        cfg_data
);
  import pdr_pkg::*;

  localparam int CNTW = $clog2(FRAME_BYTES + 1);
  localparam int AW   = $clog2(FRAME_BYTES);

  cmd_t            f_cmd, q_head;
  logic            f_push, q_full, q_valid, q_pop, build_done, rx_we;
  logic [AW-1:0]   rx_waddr;
  logic [7:0]      rx_wdata;
  logic [CNTW-1:0] frame_cnt;

  pdr_front #(.FB(FRAME_BYTES), .CNTW(CNTW), .AW(AW)) u_front (
    .clk, .rst_n, .in_valid, .in_ready, .in_item,
    .q_full, .q_push(f_push), .q_cmd(f_cmd), .build_done,
    .rx_we, .rx_waddr, .rx_wdata, .frame_cnt
  );

  pdr_queue u_queue (
    .clk, .rst_n, .push(f_push), .push_cmd(f_cmd), .pop(q_pop),
    .full(q_full), .valid(q_valid), .head(q_head)
  );

  pdr_back #(.FB(FRAME_BYTES), .NB(NAME_BYTES), .CNTW(CNTW), .AW(AW)) u_back (
    .clk, .rst_n, .q_valid, .q_cmd(q_head), .q_pop, .frame_cnt, .build_done,
    .rx_we, .rx_waddr, .rx_wdata, .cfg_wr_en, .cfg_index, .cfg_data,
    .out_valid, .out_ready, .out_item
  );
endmodule
`default_nettype wire

// File: sv/pdr_front.sv
// Front end: stores received bytes, tracks the header, classifies frames.
`timescale 1ns / 1ps
`default_nettype none
module pdr_front #(
  parameter int FB   = 2048,
  parameter int CNTW = 12,
  parameter int AW   = 11
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire pdr_pkg::in_item_t in_item,
  input  wire logic              q_full,
  output logic                   q_push,
  output pdr_pkg::cmd_t          q_cmd,
  input  wire logic              build_done,
  output logic                   rx_we,
  output logic [AW-1:0]          rx_waddr,
  output logic [7:0]             rx_wdata,
  output logic [CNTW-1:0]        frame_cnt
);
  import pdr_pkg::*;

  logic [CNTW-1:0] cnt_r, cnt_nxt, last_r, last_nxt, cnt_inc;
  logic [7:0]      hdr_r [20];
  logic [7:0]      hdr_nxt [20];
  logic [7:0]      eff [20];
  logic            bld_r, bld_nxt;
  logic            acc, push;
  logic [15:0]     etype;

  assign in_ready  = !q_full && !bld_r;
  assign acc       = in_valid && in_ready;
  assign push      = acc && (in_item.operation == OP_PUSH);
  assign rx_we     = push && (cnt_r < CNTW'(FB));
  assign rx_waddr  = cnt_r[AW-1:0];
  assign rx_wdata  = in_item.data_byte;
  assign frame_cnt = last_r;
  assign cnt_inc   = rx_we ? cnt_r + CNTW'(1) : cnt_r;
  assign etype     = {eff[12], eff[13]};

  always_comb begin
    for (int i = 0; i < 20; i++) begin
      eff[i] = (rx_we && cnt_r == CNTW'(i)) ? in_item.data_byte : hdr_r[i];
    end
  end

  always_comb begin
    cnt_nxt  = cnt_r;
    last_nxt = last_r;
    bld_nxt  = bld_r && !build_done;
    for (int i = 0; i < 20; i++) hdr_nxt[i] = hdr_r[i];
    q_push = 1'b0;
    q_cmd  = '0;
    q_cmd.nonce   = in_item.nonce;
    q_cmd.src_mac = {eff[6], eff[7], eff[8], eff[9], eff[10], eff[11]};
    q_cmd.plen    = {eff[18], eff[19]};
    if (acc && in_item.operation == OP_PULL) begin
      q_push   = 1'b1;
      q_cmd.op = CMD_PULL;
    end else if (push) begin
      if (in_item.frame_end) begin
        q_push   = 1'b1;
        cnt_nxt  = '0;
        last_nxt = cnt_inc;
        for (int i = 0; i < 20; i++) hdr_nxt[i] = '0;
        q_cmd.op = CMD_STAT;
        if (etype != ETH_DISC) begin
          q_cmd.status = ST_NOT_DISC;
        end else if (eff[14] != VER_TYPE) begin
          q_cmd.status = ST_BAD_VER;
        end else if (eff[15] != CODE_PADI && eff[15] != CODE_PADR) begin
          q_cmd.status = ST_BAD_CODE;
        end else begin
          q_cmd.status = ST_READY;
          q_cmd.op     = CMD_BUILD;
          q_cmd.pado   = (eff[15] == CODE_PADI);
          bld_nxt      = 1'b1;
        end
      end else begin
        cnt_nxt = cnt_inc;
        for (int i = 0; i < 20; i++) hdr_nxt[i] = eff[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      last_r <= '0;
      bld_r  <= 1'b0;
      for (int i = 0; i < 20; i++) hdr_r[i] <= '0;
    end else begin
      cnt_r  <= cnt_nxt;
      last_r <= last_nxt;
      bld_r  <= bld_nxt;
      for (int i = 0; i < 20; i++) hdr_r[i] <= hdr_nxt[i];
    end
  end
endmodule
`default_nettype wire

// File: sv/pdr_queue.sv
// Two-entry command queue between front and back.
`timescale 1ns / 1ps
`default_nettype none
module pdr_queue (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          push,
  input  wire pdr_pkg::cmd_t push_cmd,
  input  wire logic          pop,
  output logic               full,
  output logic               valid,
  output pdr_pkg::cmd_t      head
);
  import pdr_pkg::*;

  cmd_t       ent_r [2];
  logic       wp_r, wp_nxt, rp_r, rp_nxt;
  logic [1:0] cnt_r, cnt_nxt;

  assign full  = (cnt_r == 2'd2);
  assign valid = (cnt_r != 2'd0);
  assign head  = ent_r[rp_r];

  always_comb begin
    wp_nxt  = push ? !wp_r : wp_r;
    rp_nxt  = pop ? !rp_r : rp_r;
    cnt_nxt = cnt_r + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk) begin
    if (push) ent_r[wp_r] <= push_cmd;
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end
endmodule
`default_nettype wire

// File: sv/pdr_back.sv
// Back end: assembles replies into the transmit store and serves read-out.
`timescale 1ns / 1ps
`default_nettype none
module pdr_back #(
  parameter int FB   = 2048,
  parameter int NB   = 32,
  parameter int CNTW = 12,
  parameter int AW   = 11
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               q_valid,
  input  wire pdr_pkg::cmd_t      q_cmd,
  output logic                    q_pop,
  input  wire logic [CNTW-1:0]    frame_cnt,
  output logic                    build_done,
  input  wire logic               rx_we,
  input  wire logic [AW-1:0]      rx_waddr,
  input  wire logic [7:0]         rx_wdata,
  input  wire logic               cfg_wr_en,
  input  wire logic [2:0]         cfg_index,
  input  wire logic [63:0]        cfg_data,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output pdr_pkg::out_item_t      out_item
);
  import pdr_pkg::*;

  localparam int PW = $clog2(FB + 128);
  localparam int CW = ((CNTW > 16) ? CNTW : 16) + 2;
  localparam int TW = (PW > 16) ? PW : 16;

  typedef enum logic [14:0] {
    S_IDLE = 15'b000000000000001,
    S_HDR  = 15'b000000000000010,
    S_ANH  = 15'b000000000000100,
    S_NAME = 15'b000000000001000,
    S_CK   = 15'b000000000010000,
    S_TCHK = 15'b000000000100000,
    S_TRA  = 15'b000000001000000,
    S_TRB  = 15'b000000010000000,
    S_TEV  = 15'b000000100000000,
    S_TEH  = 15'b000001000000000,
    S_TVA  = 15'b000010000000000,
    S_TVB  = 15'b000100000000000,
    S_LEN  = 15'b001000000000000,
    S_PB   = 15'b010000000000000,
    S_RES  = 15'b100000000000000
  } state_t;

  logic [7:0]  rx_mem [FB];
  logic [7:0]  tx_mem [FB];
  logic [7:0]  rx_q, tx_q;
  logic [AW-1:0] rx_raddr, tx_addr;
  logic        tx_we;
  logic [7:0]  tx_wdata;

  logic [5:0]  name_len_r;
  logic [63:0] word_r [4];

  state_t      state_r, state_nxt;
  cmd_t        cmd_r, cmd_nxt;
  logic [5:0]  k_r, k_nxt;
  logic [15:0] j_r, j_nxt;
  logic [CW-1:0] off_r, off_nxt, lim_r, lim_nxt, avail;
  logic [PW-1:0] pos_r, pos_nxt;
  logic [7:0]  th_r [4];
  logic [7:0]  th_nxt [4];
  logic        lsb_r, lsb_nxt;
  logic [CNTW-1:0] tlen_r, tlen_nxt, idx_r, idx_nxt, idx_inc, fin_len;
  logic        pend_r, pend_nxt;
  out_item_t   res_r, res_nxt, out_r, out_nxt;
  logic        out_valid_r, out_valid_nxt;

  logic [5:0]  nlen;
  logic [7:0]  cookie_lo, name_b, hdr_b;
  logic [15:0] tag_id, tag_len, total;
  logic [TW-1:0] tot_w;
  logic [CW-1:0] tag_end;
  logic        echo;

  assign nlen      = (name_len_r > 6'(NB)) ? 6'(NB) : name_len_r;
  assign cookie_lo = (cmd_r.nonce[7:0] >= 8'd246) ? cmd_r.nonce[7:0] - 8'd246 :
                     (cmd_r.nonce[7:0] >= COOKIE_MOD) ? cmd_r.nonce[7:0] - COOKIE_MOD :
                     cmd_r.nonce[7:0];
  assign name_b    = word_r[k_r[4:3]][8*(7 - int'(k_r[2:0])) +: 8];
  assign tag_id    = {th_r[0], th_r[1]};
  assign tag_len   = {th_r[2], th_r[3]};
  assign tag_end   = off_r + CW'(4) + CW'(tag_len);
  assign echo      = (tag_id == TAG_SVC) || (tag_id == TAG_HOST) ||
                     (tag_id == TAG_RELAY);
  assign tot_w     = TW'(pos_r) - TW'(20);
  assign total     = tot_w[15:0];
  assign fin_len   = (pos_r > PW'(FB)) ? CNTW'(FB) : CNTW'(pos_r);
  assign avail     = (frame_cnt > CNTW'(20)) ? CW'(frame_cnt) - CW'(20) : '0;
  assign idx_inc   = idx_r + CNTW'(1);
  assign out_valid = out_valid_r;
  assign out_item  = out_r;

  always_comb begin
    case (k_r[4:0])
      5'd0, 5'd1, 5'd2, 5'd3, 5'd4, 5'd5:
        hdr_b = cmd_r.src_mac[8*(5 - int'(k_r[2:0])) +: 8];
      5'd12: hdr_b = ETH_DISC[15:8];
      5'd13: hdr_b = ETH_DISC[7:0];
      5'd14: hdr_b = VER_TYPE;
      5'd15: hdr_b = cmd_r.pado ? CODE_PADO : CODE_PADS;
      5'd16: hdr_b = cmd_r.pado ? 8'h00 : cmd_r.nonce[15:8];
      5'd17: hdr_b = cmd_r.pado ? 8'h00 : cmd_r.nonce[7:0];
      default: hdr_b = 8'h00;
    endcase
  end

  always_comb begin
    state_nxt     = state_r;
    cmd_nxt       = cmd_r;
    k_nxt         = k_r;
    j_nxt         = j_r;
    off_nxt       = off_r;
    lim_nxt       = lim_r;
    pos_nxt       = pos_r;
    for (int i = 0; i < 4; i++) th_nxt[i] = th_r[i];
    lsb_nxt       = lsb_r;
    tlen_nxt      = tlen_r;
    idx_nxt       = idx_r;
    pend_nxt      = pend_r;
    res_nxt       = res_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && !out_ready;
    q_pop         = 1'b0;
    build_done    = 1'b0;
    tx_we         = 1'b0;
    tx_wdata      = 8'h00;
    tx_addr       = pos_r[AW-1:0];
    rx_raddr      = AW'(CW'(20) + off_r + CW'(k_r));
    case (state_r)
      S_IDLE: begin
        tx_addr = idx_r[AW-1:0];
        if (q_valid) begin
          q_pop   = 1'b1;
          cmd_nxt = q_cmd;
          res_nxt = '0;
          case (q_cmd.op)
            CMD_STAT: begin
              res_nxt.kind   = KIND_STATUS;
              res_nxt.status = q_cmd.status;
              state_nxt      = S_RES;
            end
            CMD_PULL: begin
              if (!pend_r || idx_r >= tlen_r) begin
                pend_nxt       = 1'b0;
                res_nxt.kind   = KIND_BYTE;
                res_nxt.status = ST_NONE;
                state_nxt      = S_RES;
              end else begin
                state_nxt = S_PB;
              end
            end
            CMD_BUILD: begin
              pos_nxt   = '0;
              k_nxt     = '0;
              off_nxt   = '0;
              lim_nxt   = (CW'(q_cmd.plen) < avail) ? CW'(q_cmd.plen) : avail;
              state_nxt = S_HDR;
            end
            default: state_nxt = S_IDLE;
          endcase
        end
      end
      S_HDR: begin
        tx_we    = (pos_r < PW'(FB));
        tx_wdata = hdr_b;
        pos_nxt  = pos_r + PW'(1);
        k_nxt    = k_r + 6'd1;
        if (k_r == 6'd19) begin
          k_nxt     = '0;
          state_nxt = cmd_r.pado ? S_ANH : S_TCHK;
        end
      end
      S_ANH: begin
        tx_we   = (pos_r < PW'(FB));
        case (k_r[1:0])
          2'd0:    tx_wdata = 8'h01;
          2'd1:    tx_wdata = 8'h02;
          2'd2:    tx_wdata = 8'h00;
          default: tx_wdata = {2'b00, nlen};
        endcase
        pos_nxt = pos_r + PW'(1);
        k_nxt   = k_r + 6'd1;
        if (k_r == 6'd3) begin
          k_nxt     = '0;
          state_nxt = (nlen == 6'd0) ? S_CK : S_NAME;
        end
      end
      S_NAME: begin
        tx_we    = (pos_r < PW'(FB));
        tx_wdata = name_b;
        pos_nxt  = pos_r + PW'(1);
        k_nxt    = k_r + 6'd1;
        if (k_r == nlen - 6'd1) begin
          k_nxt     = '0;
          state_nxt = S_CK;
        end
      end
      S_CK: begin
        tx_we = (pos_r < PW'(FB));
        case (k_r[2:0])
          3'd0:    tx_wdata = 8'h01;
          3'd1:    tx_wdata = 8'h04;
          3'd2:    tx_wdata = 8'h00;
          3'd3:    tx_wdata = 8'h02;
          3'd4:    tx_wdata = cmd_r.nonce[15:8];
          default: tx_wdata = cookie_lo;
        endcase
        pos_nxt = pos_r + PW'(1);
        k_nxt   = k_r + 6'd1;
        if (k_r == 6'd5) begin
          k_nxt     = '0;
          state_nxt = S_TCHK;
        end
      end
      S_TCHK: begin
        k_nxt = '0;
        if (off_r + CW'(4) <= lim_r) begin
          state_nxt = S_TRA;
        end else begin
          lsb_nxt   = 1'b0;
          state_nxt = S_LEN;
        end
      end
      S_TRA: state_nxt = S_TRB;
      S_TRB: begin
        th_nxt[k_r[1:0]] = rx_q;
        if (k_r == 6'd3) begin
          k_nxt     = '0;
          state_nxt = S_TEV;
        end else begin
          k_nxt     = k_r + 6'd1;
          state_nxt = S_TRA;
        end
      end
      S_TEV: begin
        if (tag_end > lim_r) begin
          lsb_nxt   = 1'b0;
          state_nxt = S_LEN;
        end else if (echo) begin
          k_nxt     = '0;
          state_nxt = S_TEH;
        end else begin
          off_nxt   = tag_end;
          state_nxt = S_TCHK;
        end
      end
      S_TEH: begin
        tx_we    = (pos_r < PW'(FB));
        tx_wdata = th_r[k_r[1:0]];
        pos_nxt  = pos_r + PW'(1);
        k_nxt    = k_r + 6'd1;
        if (k_r == 6'd3) begin
          j_nxt = '0;
          if (tag_len == 16'd0) begin
            off_nxt   = tag_end;
            state_nxt = S_TCHK;
          end else begin
            state_nxt = S_TVA;
          end
        end
      end
      S_TVA: begin
        rx_raddr  = AW'(CW'(24) + off_r + CW'(j_r));
        state_nxt = S_TVB;
      end
      S_TVB: begin
        tx_we    = (pos_r < PW'(FB));
        tx_wdata = rx_q;
        pos_nxt  = pos_r + PW'(1);
        j_nxt    = j_r + 16'd1;
        if (j_r + 16'd1 == tag_len) begin
          off_nxt   = tag_end;
          state_nxt = S_TCHK;
        end else begin
          state_nxt = S_TVA;
        end
      end
      S_LEN: begin
        tx_we    = 1'b1;
        tx_addr  = lsb_r ? AW'(19) : AW'(18);
        tx_wdata = lsb_r ? total[7:0] : total[15:8];
        lsb_nxt  = 1'b1;
        if (lsb_r) begin
          build_done           = 1'b1;
          tlen_nxt             = fin_len;
          idx_nxt              = '0;
          pend_nxt             = 1'b1;
          res_nxt              = '0;
          res_nxt.kind         = KIND_STATUS;
          res_nxt.status       = ST_READY;
          res_nxt.reply_length = 12'(fin_len);
          state_nxt            = S_RES;
        end
      end
      S_PB: begin
        tx_addr              = idx_r[AW-1:0];
        res_nxt              = '0;
        res_nxt.kind         = KIND_BYTE;
        res_nxt.status       = ST_READY;
        res_nxt.reply_byte   = tx_q;
        res_nxt.reply_length = 12'(tlen_r);
        if (idx_inc >= tlen_r) begin
          res_nxt.reply_last = 1'b1;
          pend_nxt           = 1'b0;
          idx_nxt            = '0;
        end else begin
          idx_nxt = idx_inc;
        end
        state_nxt = S_RES;
      end
      S_RES: begin
        tx_addr = idx_r[AW-1:0];
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_nxt       = res_r;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rx_we) rx_mem[rx_waddr] <= rx_wdata;
    rx_q <= rx_mem[rx_raddr];
    if (tx_we) tx_mem[tx_addr] <= tx_wdata;
    tx_q <= tx_mem[tx_addr];
  end

  always_ff @(posedge clk) begin
    cmd_r <= cmd_nxt;
    k_r   <= k_nxt;
    j_r   <= j_nxt;
    off_r <= off_nxt;
    lim_r <= lim_nxt;
    pos_r <= pos_nxt;
    lsb_r <= lsb_nxt;
    res_r <= res_nxt;
    out_r <= out_nxt;
    for (int i = 0; i < 4; i++) th_r[i] <= th_nxt[i];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      tlen_r      <= '0;
      idx_r       <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
      name_len_r  <= '0;
      for (int i = 0; i < 4; i++) word_r[i] <= '0;
    end else begin
      state_r     <= state_nxt;
      tlen_r      <= tlen_nxt;
      idx_r       <= idx_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) begin
        case (cfg_index)
          REG_NAME_LEN: name_len_r <= cfg_data[5:0];
          REG_WORD_0:   word_r[0]  <= cfg_data;
          REG_WORD_1:   word_r[1]  <= cfg_data;
          REG_WORD_2:   word_r[2]  <= cfg_data;
          REG_WORD_3:   word_r[3]  <= cfg_data;
          default:      name_len_r <= name_len_r;
        endcase
      end
    end
  end
endmodule
`default_nettype wire

// File: sv/pdr_chk.sv
// Port-level checks for the PPPoE discovery responder.
`timescale 1ns / 1ps
`default_nettype none
module pdr_chk (
  input wire logic               clk,
  input wire logic               rst_n,
  input wire logic               out_valid,
  input wire logic               out_ready,
  input wire pdr_pkg::out_item_t out_item
);
  import pdr_pkg::*;

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_item))
    else $error("result dropped while stalled");

  a_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.reply_last |->
      out_item.kind == KIND_BYTE && out_item.status == ST_READY)
    else $error("last flag on a non-byte result");

  a_stat: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.kind == KIND_STATUS |->
      out_item.reply_byte == 8'h00 && !out_item.reply_last)
    else $error("status result carries byte data");

  a_rej: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.status != ST_READY |-> out_item.reply_length == 12'd0)
    else $error("rejected result carries a length");
endmodule

bind pppoe_discovery_responder pdr_chk u_pdr_chk (
  .clk(clk), .rst_n(rst_n), .out_valid(out_valid), .out_ready(out_ready),
  .out_item(out_item)
);
`default_nettype wire
